// ===== src/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg
// types, constants and helper functions shared by the date difference block
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DistW  = 22;
  // day number of any 14-bit year stays below 2^23
  localparam int unsigned DayNumW = 23;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // reciprocal of 25 scaled by 2^17, exact floor for dividends below 2^13
  localparam logic [12:0] Recip25  = 13'd5243;
  localparam int unsigned Recip25Sh = 17;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // per-stage load enables handed to each lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdd_stage_en_t;

  // what one lane delivers to the merge stage
  typedef struct packed {
    logic               ok;
    logic [DayNumW-1:0] day_num;
  } gdd_day_t;

  // days in the whole months before month m in a common year
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(t / 25) for t below 2^13 by reciprocal multiply
  function automatic logic [8:0] div25(input logic [12:0] t);
    logic [25:0] p;
    p = {13'd0, t} * {13'd0, Recip25};
    return p[Recip25Sh+8:Recip25Sh];
  endfunction

endpackage

// ===== src/gdd_lane.sv =====
// ----------------------------------------------------------------------------
// gdd_lane
// three-stage pipeline turning one date into its day number
// ----------------------------------------------------------------------------
module gdd_lane (
  input  logic                         clk_i,
  input  gdd_pkg::gdd_stage_en_t       en_i,
  input  logic [gdd_pkg::YearW-1:0]    year_i,
  input  logic [gdd_pkg::MonthW-1:0]   month_i,
  input  logic [gdd_pkg::DayW-1:0]     day_i,
  output gdd_pkg::gdd_day_t            res_o
);
  import gdd_pkg::*;

  // stage 1: register date, month table lookup
  logic [YearW-1:0] y1_q;
  logic [9:0]       md1_q;
  logic             late1_q;
  logic             ok1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      y1_q    <= year_i;
      md1_q   <= {1'b0, month_start(month_i)} + {5'd0, day_i};
      late1_q <= (month_i > MonthFeb);
      ok1_q   <= (month_i != '0) && (month_i <= MonthDec) && (day_i != '0);
    end
  end

  // stage 2: constant divisions and the year term
  logic [12:0]        q4_d;
  logic [12:0]        t100_d, t400_d;
  logic [11:0]        u_d;
  logic [9:0]         v_d;
  logic [14:0]        y99_d, y399_d;
  logic [DayNumW-1:0] y365_d;

  always_comb begin
    y99_d  = {1'b0, y1_q} + 15'd99;
    y399_d = {1'b0, y1_q} + 15'd399;
    q4_d   = 13'(({1'b0, y1_q} + 15'd3) >> 2);
    t100_d = y99_d[14:2];
    t400_d = {2'b00, y399_d[14:4]};
    u_d    = y1_q[13:2];
    v_d    = y1_q[13:4];
    y365_d = {{(DayNumW-YearW){1'b0}}, y1_q} * DayNumW'(365);
  end

  logic [12:0]        q4_q;
  logic [8:0]         q100_q, q400_q, qa_q, qb_q;
  logic [11:0]        u_q;
  logic [9:0]         v_q;
  logic [3:0]         ylo_q;
  logic [DayNumW-1:0] y365_q;
  logic [9:0]         md2_q;
  logic               late2_q;
  logic               ok2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      q4_q    <= q4_d;
      q100_q  <= div25(t100_d);
      q400_q  <= div25(t400_d);
      qa_q    <= div25({1'b0, u_d});
      qb_q    <= div25({3'b000, v_d});
      u_q     <= u_d;
      v_q     <= v_d;
      ylo_q   <= y1_q[3:0];
      y365_q  <= y365_d;
      md2_q   <= md1_q;
      late2_q <= late1_q;
      ok2_q   <= ok1_q;
    end
  end

  // stage 3: leap test and final sum
  logic               div4, div100, div400, leap;
  logic [12:0]        leaps;
  logic [DayNumW-1:0] day_d;

  always_comb begin
    div4   = (ylo_q[1:0] == 2'b00);
    div100 = div4 && ({2'b00, u_q} == (14'(qa_q) * 14'd25));
    div400 = (ylo_q == 4'd0) && ({4'd0, v_q} == (14'(qb_q) * 14'd25));
    leap   = div400 || (div4 && !div100);
    leaps  = q4_q + 13'(q400_q) - 13'(q100_q);
    day_d  = y365_q + DayNumW'(leaps) + DayNumW'(md2_q)
           + DayNumW'(late2_q && leap);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      res_o.day_num <= day_d;
      res_o.ok      <= ok2_q;
    end
  end

endmodule

// ===== src/gdd_merge.sv =====
// ----------------------------------------------------------------------------
// gdd_merge
// combines the two lane day numbers into a saturated absolute distance
// ----------------------------------------------------------------------------
module gdd_merge (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  gdd_pkg::gdd_day_t           a_i,
  input  gdd_pkg::gdd_day_t           b_i,
  output logic [gdd_pkg::DistW-1:0]   dist_o,
  output logic                        bad_o
);
  import gdd_pkg::*;

  logic [DayNumW-1:0] diff;
  logic               bad;
  logic [DistW-1:0]   dist_d;

  always_comb begin
    diff = (a_i.day_num >= b_i.day_num) ? (a_i.day_num - b_i.day_num)
                                        : (b_i.day_num - a_i.day_num);
    bad  = !a_i.ok || !b_i.ok;
    if (bad) begin
      dist_d = '0;
    end else if (diff > DayNumW'(DistMax)) begin
      dist_d = DistMax;
    end else begin
      dist_d = diff[DistW-1:0];
    end
  end

  // output register of the block
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_o <= dist_d;
      bad_o  <= bad;
    end
  end

endmodule

// ===== src/gregorian_date_difference.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_difference
// days between two gregorian dates, one date pair per transfer
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries a date pair per transfer; master stream returns the
//   absolute day distance in tdata and the bad-date flag in tuser
//   two lanes turn each date into a day number, a merge stage forms the
//   saturated distance and holds it in the output register
//   a pair passes lane stages s1, s2, s3 and then the merge output register
//   throughput: one date pair per cycle while m_axis_tready is high, set by the
//   four-stage pipeline whose every stage takes a new item in the cycle it is freed
//   stall: each stage holds while the stage after it is full and stalled;
//   s_axis_tready drops only when all four stages are full and m_axis_tready is low
//   reset: rst_ni low empties the pipeline, no result is pending afterwards
//   a month outside 1..12 or a zero day gives tuser 1 and distance 0
// ----------------------------------------------------------------------------
module gregorian_date_difference (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_year, first_month, first_day, second_year, second_month,
  // second_day, zero fill
  input  logic [gdd_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // day_distance, zero fill
  output logic [gdd_pkg::OutDataW-1:0]   m_axis_tdata,
  // bad_date
  output logic                           m_axis_tuser
);
  import gdd_pkg::*;

  // pipeline occupancy
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  always_comb begin
    rdy4 = !v4_q || m_axis_tready;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  gdd_stage_en_t en;
  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  gdd_day_t day_a, day_b;

  gdd_lane u_lane_a (
    .clk_i   (clk_i),
    .en_i    (en),
    .year_i  (s_axis_tdata[13:0]),
    .month_i (s_axis_tdata[17:14]),
    .day_i   (s_axis_tdata[22:18]),
    .res_o   (day_a)
  );

  gdd_lane u_lane_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .year_i  (s_axis_tdata[36:23]),
    .month_i (s_axis_tdata[40:37]),
    .day_i   (s_axis_tdata[45:41]),
    .res_o   (day_b)
  );

  logic [DistW-1:0] distance;
  logic             bad;

  gdd_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (rdy4),
    .a_i    (day_a),
    .b_i    (day_b),
    .dist_o (distance),
    .bad_o  (bad)
  );

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{(OutDataW-DistW){1'b0}}, distance};
  assign m_axis_tuser  = bad;

`ifndef ASSERT_OFF
  // an accepted pair always occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted transfer lost at stage 1");

  // a full pipeline with a stalled receiver must refuse input
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline full and stalled");

  // a bad date never carries a distance
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("bad date with nonzero distance");

  // an empty first stage frees the input side regardless of the receiver
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q) |-> s_axis_tready)
    else $error("input refused while first stage empty");
`endif

endmodule

// ===== test/gregorian_date_difference_tb.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_difference_tb
// self-checking bench for the gregorian day distance block: date pairs go in
// on the slave stream, an in-bench day count predicts each distance and flag,
// and every master transfer is matched against the oldest prediction
// ----------------------------------------------------------------------------
module gregorian_date_difference_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongHold    = 80;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PairW       = 2 * (YearW + MonthW + DayW);

  // packed from the top down so that first_year lands in the lowest bits
  typedef struct packed {
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
  } date_pair_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             bad;
  } day_gap_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // first_year, first_month, first_day, second_year, second_month,
  // second_day, zero fill
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // day_distance, zero fill
  logic [OutDataW-1:0] m_axis_tdata;
  // bad_date
  logic                m_axis_tuser;

  day_gap_t    pending_gaps[$];
  day_gap_t    due;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b0;
  bit          hold_req    = 1'b0;

  gregorian_date_difference dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned days_from_year_zero(int unsigned y, int unsigned m,
                                                      int unsigned d);
    int unsigned month_days;
    int unsigned n;
    case (m)
      2:       month_days = 31;
      3:       month_days = 59;
      4:       month_days = 90;
      5:       month_days = 120;
      6:       month_days = 151;
      7:       month_days = 181;
      8:       month_days = 212;
      9:       month_days = 243;
      10:      month_days = 273;
      11:      month_days = 304;
      12:      month_days = 334;
      default: month_days = 0;
    endcase
    // leap years in 0..y-1, year 0 included
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + month_days + d;
    if (m > 2 && (y % 400 == 0 || (y % 100 != 0 && y % 4 == 0))) begin
      n++;
    end
    return n;
  endfunction

  function automatic day_gap_t predict_distance(date_pair_t p);
    day_gap_t    r;
    int unsigned a;
    int unsigned b;
    int unsigned span;
    if (p.first_month == '0 || p.first_month > MonthDec || p.first_day == '0 ||
        p.second_month == '0 || p.second_month > MonthDec || p.second_day == '0) begin
      r.distance = '0;
      r.bad      = 1'b1;
    end else begin
      a    = days_from_year_zero(p.first_year, p.first_month, p.first_day);
      b    = days_from_year_zero(p.second_year, p.second_month, p.second_day);
      span = (a >= b) ? a - b : b - a;
      r.distance = (span > DistMax) ? DistMax : span[DistW-1:0];
      r.bad      = 1'b0;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ idling

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    int unsigned gap;
    int unsigned run;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      run = $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_gaps.size() == 0) begin
        $error("result transfer with no date pair outstanding");
        errors++;
      end else begin
        due = pending_gaps.pop_front();
        if (m_axis_tdata[DistW-1:0] !== due.distance) begin
          $error("day_distance: expected %0d, got %0d", due.distance,
                 m_axis_tdata[DistW-1:0]);
          errors++;
        end
        if (m_axis_tuser !== due.bad) begin
          $error("bad_date: expected %0b, got %0b", due.bad, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic send_dates(input logic [YearW-1:0] y1, input logic [MonthW-1:0] m1,
                            input logic [DayW-1:0] d1, input logic [YearW-1:0] y2,
                            input logic [MonthW-1:0] m2, input logic [DayW-1:0] d2);
    date_pair_t  p;
    int unsigned gap;
    p.first_year   = y1;
    p.first_month  = m1;
    p.first_day    = d1;
    p.second_year  = y2;
    p.second_month = m2;
    p.second_day   = d2;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - PairW){1'b0}}, p};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_gaps.insert(pending_gaps.size(), predict_distance(p));
  endtask

  // drop valid in the step of the last transfer, then wait for the next clock edge
  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_gaps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [YearW-1:0] rand_year();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return YearW'($urandom_range(0, 9999));
    end
    // around century and quad-century boundaries
    if (r < 88) begin
      return YearW'($urandom_range(0, 99) * 100 + $urandom_range(0, 4));
    end
    return YearW'($urandom_range(10000, 16383));
  endfunction

  function automatic logic [MonthW-1:0] rand_month();
    if ($urandom_range(0, 99) < 95) begin
      return MonthW'($urandom_range(1, 12));
    end
    return $urandom_range(0, 3) == 0 ? 4'd0 : MonthDec + MonthW'($urandom_range(1, 3));
  endfunction

  function automatic logic [DayW-1:0] rand_day();
    return ($urandom_range(0, 99) < 97) ? DayW'($urandom_range(1, 31)) : '0;
  endfunction

  task automatic send_random_pair();
    logic [YearW-1:0] y1;
    logic [YearW-1:0] y2;
    y1 = rand_year();
    // close dates exercise the month and leap-day terms
    if ($urandom_range(0, 99) < 30) begin
      y2 = y1 + YearW'($urandom_range(0, 6)) - YearW'(3);
    end else begin
      y2 = rand_year();
    end
    send_dates(y1, rand_month(), rand_day(), y2, rand_month(), rand_day());
  endtask

  // ------------------------------------------------------------------ tests

  task automatic test_extremes();
    gaps_on = 1'b0;
    send_dates(0, 1, 1, 0, 1, 1);
    send_dates(0, 1, 1, 9999, 12, 31);
    send_dates(9999, 12, 31, 0, 1, 1);
    // top years push the distance past 22 bits
    send_dates(16383, 12, 31, 0, 1, 1);
    send_dates(0, 1, 1, 16383, 12, 31);
    send_dates(16383, 12, 31, 16383, 1, 1);
    send_dates(5000, 6, 15, 5000, 6, 15);
    end_burst();
    wait_drained();
  endtask

  task automatic test_leap_rules();
    gaps_on = 1'b0;
    send_dates(2000, 2, 29, 2000, 3, 1);
    send_dates(1900, 2, 28, 1900, 3, 1);
    send_dates(0, 2, 28, 0, 3, 1);
    send_dates(2024, 1, 1, 2025, 1, 1);
    send_dates(2023, 1, 1, 2024, 1, 1);
    send_dates(2100, 12, 31, 2101, 1, 1);
    send_dates(400, 3, 1, 399, 3, 1);
    // day past the end of the month rolls into the next one
    send_dates(1999, 2, 31, 1999, 3, 3);
    end_burst();
    wait_drained();
  endtask

  task automatic test_bad_dates();
    gaps_on = 1'b0;
    send_dates(2024, 0, 10, 2024, 5, 5);
    send_dates(2024, 13, 10, 2024, 5, 5);
    send_dates(2024, 15, 31, 2024, 5, 5);
    send_dates(2024, 5, 0, 2024, 5, 5);
    send_dates(2024, 5, 5, 2024, 0, 5);
    send_dates(2024, 5, 5, 2024, 14, 5);
    send_dates(2024, 5, 5, 2024, 5, 0);
    send_dates(16383, 15, 0, 16383, 15, 0);
    end_burst();
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random_pair();
    end_burst();
    wait_drained();
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    repeat (3) begin
      repeat (10) send_random_pair();
      end_burst();
      wait_drained();
    end
  endtask

  task automatic test_random();
    for (int chunk = 0; chunk < 8; chunk++) begin
      gaps_on = (chunk % 3 != 2);
      repeat (200) send_random_pair();
    end
    end_burst();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_leap_rules();
    test_bad_dates();
    test_receiver_hold();
    test_drain_pause();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gdd_pkg.sv
src/gdd_lane.sv
src/gdd_merge.sv
src/gregorian_date_difference.sv
test/gregorian_date_difference_tb.sv
